### rtl/core/msm_pkg.sv
// Package for the masked signature matcher.
// Holds the command codes and the default table sizes; no dependencies.
`default_nettype none

package msm_pkg;

  // Default number of signatures and bytes per signature.
  localparam int SigCountDefault  = 16;
  localparam int SigMaxLenDefault = 32;

  // Width of the reported match index.
  localparam int MatchIdxW = 4;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdLoad   = 2'd1,
    CmdBuffer = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

### rtl/core/masked_signature_matcher.sv
// Top level of the masked signature matcher: head, chain of signature cells,
// and the result register. Depends on msm_pkg, msm_head and msm_cell.
//
// The block keeps a table of up to SIG_COUNT byte signatures, each up to
// SIG_MAX_LEN pattern bytes with a mask byte apiece, and checks streamed
// buffers against all of them. Command 0 clears the table, command 1 loads
// one pattern and mask byte into the signature being built (last closes it),
// and command 2 streams one buffer byte (last closes the buffer). Each
// signature lives in a cell of its own; the cells form a chain through which
// every command travels, two register stages per cell, so each cell sees the
// commands in order and the running first-match result is carried along with
// the buffer's last byte. One input transfer is taken every cycle whenever the
// result register is free or being emptied; a result transfer leaves once the
// buffer's last byte has passed the head register, both stages of every cell
// and the result register. Only the last buffer byte produces a result:
// match_found_o and the low four bits of the first matching signature's
// load-order index, or zeros when nothing matched. Command 3 is taken and
// does nothing.
`default_nettype none

module masked_signature_matcher
  import msm_pkg::*;
#(
  parameter int SIG_COUNT   = SigCountDefault,
  parameter int SIG_MAX_LEN = SigMaxLenDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [1:0]           cmd_i,
  input  wire  [7:0]           data_byte_i,
  input  wire  [7:0]           mask_byte_i,
  input  wire                  last_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 match_found_o,
  output logic [MatchIdxW-1:0] match_index_o
);

  localparam int TW   = (SIG_COUNT > 1) ? $clog2(SIG_COUNT) : 1;
  localparam int PW   = $clog2(SIG_MAX_LEN + 1);
  localparam int TAGW = 2 + 3 + 2 * TW + 2 * PW + 16 + 1;

  typedef struct packed {
    cmd_e          kind;
    logic          last;
    logic          wr;
    logic          set_len;
    logic [TW-1:0] target;
    logic [PW-1:0] pos;
    logic [PW-1:0] len;
    logic [7:0]    data;
    logic [7:0]    mask;
    logic          found;
    logic [TW-1:0] idx;
  } tag_t;

  // The whole chain moves together; it holds only while a result waits.
  logic                 adv;
  logic                 acc;
  logic                 chain_valid [SIG_COUNT + 1];
  logic [TAGW-1:0]      chain_tag   [SIG_COUNT + 1];
  tag_t                 tail;
  logic                 out_valid_q;
  logic                 found_q;
  logic [MatchIdxW-1:0] index_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  msm_head #(
    .SIG_COUNT   (SIG_COUNT),
    .SIG_MAX_LEN (SIG_MAX_LEN)
  ) u_head (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .acc_i       (acc),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .mask_byte_i (mask_byte_i),
    .last_i      (last_i),
    .tag_valid_o (chain_valid[0]),
    .tag_o       (chain_tag[0])
  );

  for (genvar g = 0; g < SIG_COUNT; g++) begin : g_cell
    msm_cell #(
      .SIG_COUNT   (SIG_COUNT),
      .SIG_MAX_LEN (SIG_MAX_LEN),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .tag_valid_i (chain_valid[g]),
      .tag_i       (chain_tag[g]),
      .tag_valid_o (chain_valid[g + 1]),
      .tag_o       (chain_tag[g + 1])
    );
  end

  assign tail = chain_tag[SIG_COUNT];

  // Result register: loaded when the buffer's last byte leaves the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain_valid[SIG_COUNT] && (tail.kind == CmdBuffer) && tail.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      found_q <= tail.found;
      index_q <= tail.found ? MatchIdxW'(tail.idx) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_found_o = found_q;
  assign match_index_o = index_q;

endmodule

`default_nettype wire

### rtl/core/msm_head.sv
// Head of the matcher chain: tracks table fill, load and buffer position, and turns each
// accepted clear, load or buffer command into a registered tag for the first cell. Uses msm_pkg.
`default_nettype none

module msm_head
  import msm_pkg::*;
#(
  parameter int SIG_COUNT   = SigCountDefault,
  parameter int SIG_MAX_LEN = SigMaxLenDefault
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        adv_i,
  input  wire                        acc_i,
  input  wire  [1:0]                 cmd_i,
  input  wire  [7:0]                 data_byte_i,
  input  wire  [7:0]                 mask_byte_i,
  input  wire                        last_i,
  output logic                       tag_valid_o,
  output logic [(2 + 3 + 2 * (SIG_COUNT > 1 ? $clog2(SIG_COUNT) : 1)
                 + 2 * $clog2(SIG_MAX_LEN + 1) + 16 + 1) - 1:0] tag_o
);

  localparam int TW = (SIG_COUNT > 1) ? $clog2(SIG_COUNT) : 1;
  localparam int EW = $clog2(SIG_COUNT + 1);
  localparam int PW = $clog2(SIG_MAX_LEN + 1);

  typedef struct packed {
    cmd_e          kind;
    logic          last;
    logic          wr;
    logic          set_len;
    logic [TW-1:0] target;
    logic [PW-1:0] pos;
    logic [PW-1:0] len;
    logic [7:0]    data;
    logic [7:0]    mask;
    logic          found;
    logic [TW-1:0] idx;
  } tag_t;

  logic [EW-1:0] entry_cnt_q, entry_cnt_d;
  logic [PW-1:0] load_pos_q, load_pos_d;
  logic [PW-1:0] buf_pos_q, buf_pos_d;
  logic          tag_valid_q, tag_valid_d;
  tag_t          tag_q, tag_d;
  logic          full;
  logic          wr;
  logic [PW-1:0] next_lp;

  assign full    = (entry_cnt_q >= EW'(SIG_COUNT));
  assign wr      = !full && (load_pos_q < PW'(SIG_MAX_LEN));
  assign next_lp = load_pos_q + PW'(wr);

  always_comb begin
    entry_cnt_d = entry_cnt_q;
    load_pos_d  = load_pos_q;
    buf_pos_d   = buf_pos_q;
    tag_valid_d = 1'b0;
    tag_d         = tag_q;
    tag_d.kind    = cmd_e'(cmd_i);
    tag_d.last    = last_i;
    tag_d.wr      = 1'b0;
    tag_d.set_len = 1'b0;
    tag_d.target  = entry_cnt_q[TW-1:0];
    tag_d.pos     = load_pos_q;
    tag_d.len     = next_lp;
    tag_d.data    = data_byte_i;
    tag_d.mask    = mask_byte_i;
    tag_d.found   = 1'b0;
    tag_d.idx     = '0;
    if (acc_i) begin
      unique case (cmd_i)
        CmdClear: begin
          entry_cnt_d = '0;
          load_pos_d  = '0;
          buf_pos_d   = '0;
          tag_valid_d = 1'b1;
        end
        CmdLoad: begin
          buf_pos_d   = '0;
          tag_valid_d = 1'b1;
          tag_d.wr    = wr;
          if (!full) begin
            if (last_i) begin
              tag_d.set_len = 1'b1;
              entry_cnt_d   = entry_cnt_q + EW'(1);
              load_pos_d    = '0;
            end else begin
              load_pos_d = next_lp;
            end
          end
        end
        CmdBuffer: begin
          tag_valid_d = 1'b1;
          tag_d.pos   = buf_pos_q;
          if (buf_pos_q < PW'(SIG_MAX_LEN)) begin
            buf_pos_d = buf_pos_q + PW'(1);
          end
          if (last_i) begin
            buf_pos_d = '0;
          end
        end
        default: begin
          tag_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
      load_pos_q  <= '0;
      buf_pos_q   <= '0;
      tag_valid_q <= 1'b0;
    end else if (adv_i) begin
      entry_cnt_q <= entry_cnt_d;
      load_pos_q  <= load_pos_d;
      buf_pos_q   <= buf_pos_d;
      tag_valid_q <= tag_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q <= tag_d;
    end
  end

  assign tag_valid_o = tag_valid_q;
  assign tag_o       = tag_q;

endmodule

`default_nettype wire

### rtl/core/msm_cell.sv
// One cell of the matcher chain: stores one signature and tracks its mismatch flag.
// Two register stages per cell; depends on msm_pkg.
`default_nettype none

module msm_cell
  import msm_pkg::*;
#(
  parameter int SIG_COUNT   = SigCountDefault,
  parameter int SIG_MAX_LEN = SigMaxLenDefault,
  parameter int CELL_IDX    = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        adv_i,
  input  wire                        tag_valid_i,
  input  wire  [(2 + 3 + 2 * (SIG_COUNT > 1 ? $clog2(SIG_COUNT) : 1)
                 + 2 * $clog2(SIG_MAX_LEN + 1) + 16 + 1) - 1:0] tag_i,
  output logic                       tag_valid_o,
  output logic [(2 + 3 + 2 * (SIG_COUNT > 1 ? $clog2(SIG_COUNT) : 1)
                 + 2 * $clog2(SIG_MAX_LEN + 1) + 16 + 1) - 1:0] tag_o
);

  localparam int TW = (SIG_COUNT > 1) ? $clog2(SIG_COUNT) : 1;
  localparam int PW = $clog2(SIG_MAX_LEN + 1);
  localparam int AW = (SIG_MAX_LEN > 1) ? $clog2(SIG_MAX_LEN) : 1;

  typedef struct packed {
    cmd_e          kind;
    logic          last;
    logic          wr;
    logic          set_len;
    logic [TW-1:0] target;
    logic [PW-1:0] pos;
    logic [PW-1:0] len;
    logic [7:0]    data;
    logic [7:0]    mask;
    logic          found;
    logic [TW-1:0] idx;
  } tag_t;

  tag_t          in_tag;
  tag_t          mid_tag_q;
  tag_t          out_tag_q, out_tag_d;
  logic          mid_valid_q;
  logic          out_valid_q;
  logic          mine;

  // Signature storage: pattern in the high byte, mask in the low byte.
  logic [15:0]   sig_mem [SIG_MAX_LEN];
  logic [15:0]   rd_q;
  logic          cmp_en_q;
  logic          live_q;
  logic          sig_valid_q;
  logic [PW-1:0] sig_len_q;
  logic          mism_q;
  logic          byte_bad;
  logic          flag_now;

  assign in_tag = tag_i;
  assign mine   = (in_tag.target == TW'(CELL_IDX));

  // First stage: table writes and the registered signature read.
  always_ff @(posedge clk_i) begin
    if (adv_i && tag_valid_i) begin
      if (in_tag.kind == CmdLoad && in_tag.wr && mine) begin
        sig_mem[in_tag.pos[AW-1:0]] <= {in_tag.data, in_tag.mask};
      end
      rd_q      <= sig_mem[in_tag.pos[AW-1:0]];
      cmp_en_q  <= sig_valid_q && (in_tag.pos < sig_len_q);
      live_q    <= sig_valid_q;
    end
    if (adv_i) begin
      mid_tag_q <= in_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_valid_q <= 1'b0;
      sig_len_q   <= '0;
      mid_valid_q <= 1'b0;
    end else if (adv_i) begin
      mid_valid_q <= tag_valid_i;
      if (tag_valid_i) begin
        if (in_tag.kind == CmdClear) begin
          sig_valid_q <= 1'b0;
        end else if (in_tag.kind == CmdLoad && in_tag.set_len && mine) begin
          sig_valid_q <= 1'b1;
          sig_len_q   <= in_tag.len;
        end
      end
    end
  end

  // Second stage: masked compare and first-match selection.
  assign byte_bad = cmp_en_q &&
                    (((mid_tag_q.data ^ rd_q[15:8]) & rd_q[7:0]) != 8'd0);
  assign flag_now = mism_q || byte_bad;

  always_comb begin
    out_tag_d = mid_tag_q;
    if (mid_tag_q.kind == CmdBuffer && mid_tag_q.last && !mid_tag_q.found &&
        live_q && !flag_now) begin
      out_tag_d.found = 1'b1;
      out_tag_d.idx   = TW'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mism_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= mid_valid_q;
      if (mid_valid_q) begin
        if (mid_tag_q.kind == CmdBuffer && !mid_tag_q.last) begin
          mism_q <= flag_now;
        end else begin
          mism_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_tag_q <= out_tag_d;
    end
  end

  assign tag_valid_o = out_valid_q;
  assign tag_o       = out_tag_q;

endmodule

`default_nettype wire
